>>> src/adcp_pkg.sv
package adcp_pkg;

	localparam int FifoDepthDefault = 16;

	// Request types.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Port offsets.
	localparam logic [3:0] PORT_RESET   = 4'h6;
	localparam logic [3:0] PORT_DATA    = 4'hA;
	localparam logic [3:0] PORT_COMMAND = 4'hC;
	localparam logic [3:0] PORT_STATUS  = 4'hE;

	// Command codes.
	localparam logic [7:0] CMD_NONE       = 8'h00;
	localparam logic [7:0] CMD_DMA_LENGTH = 8'h14;
	localparam logic [7:0] CMD_TIME_CONST = 8'h40;
	localparam logic [7:0] CMD_PAUSE      = 8'h80;
	localparam logic [7:0] CMD_DMA_HALT   = 8'hD0;
	localparam logic [7:0] CMD_SPK_ON     = 8'hD1;
	localparam logic [7:0] CMD_SPK_OFF    = 8'hD3;
	localparam logic [7:0] CMD_DMA_RESUME = 8'hD4;
	localparam logic [7:0] CMD_INVERT     = 8'hE0;
	localparam logic [7:0] CMD_VERSION    = 8'hE1;
	localparam logic [7:0] CMD_IRQ        = 8'hF2;

	// Reply and status bytes.
	localparam logic [7:0] RESET_REPLY   = 8'hAA;
	localparam logic [7:0] VERSION_MAJOR = 8'h02;
	localparam logic [7:0] VERSION_MINOR = 8'h01;
	localparam logic [7:0] STATUS_SET    = 8'h80;
	localparam logic [7:0] STATUS_CLEAR  = 8'h00;
	localparam logic [7:0] UNMAPPED_READ = 8'hFF;
	localparam logic [7:0] SAMPLE_BIAS   = 8'h80;

	// Rate divider.
	localparam int RATE_W = 20;
	localparam int DIVISOR_W = 9;
	localparam logic [RATE_W-1:0] RATE_NUMERATOR = 20'd1000000;
	localparam logic [RATE_W-1:0] RATE_RESET     = 20'd22050;
	localparam logic [DIVISOR_W-1:0] DIVISOR_BASE = 9'd256;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] port_offset;
		logic [7:0] write_data;
		logic [7:0] dma_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic signed [15:0] sample_out;
		logic              dma_taken;
		logic              irq_pulse;
		logic [RATE_W-1:0] sample_rate_hz;
	} rsp_t;

endpackage

>>> src/adcp_stream_if.sv
interface adcp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/audio_dsp_command_port.sv
// Command port of an audio DSP. Each request beat is a port write, a port
// read or a sample tick, and each gives exactly one result beat. A request
// is accepted in the idle state and carried out in the exec state. A data
// read that pops the reply FIFO also passes through a pop state, and the
// version command through a second push state, since it pushes two bytes
// through the single FIFO write port. Setting the time constant runs a
// 20-step restoring divider for 1000000 / (256 - v) before the result beat
// is offered. The block takes the next request once the result beat has
// been taken. The reply FIFO holds FIFO_DEPTH bytes and drops pushes when
// full; no clearing pass runs after reset.
module audio_dsp_command_port import adcp_pkg::*; #(
	parameter int FIFO_DEPTH = FifoDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	adcp_stream_if.sink   cmd,
	adcp_stream_if.source rsp
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(FIFO_DEPTH);
	localparam logic [PW-1:0] HEAD_LAST  = PW'(FIFO_DEPTH - 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_PUSH2 = 6'b000100,
		ST_POP   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	cmd_t   item_q;

	logic [7:0]  pend_q, pend_d;
	logic        second_q, second_d;
	logic        active_q, active_d;
	logic [15:0] remain_q, remain_d;
	logic        spk_q, spk_d;
	logic [RATE_W-1:0] rate_q, rate_d;

	logic [PW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    fifo_mem [FIFO_DEPTH];
	logic [7:0]    rdata_q;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [CW:0]   tail_sum;
	logic [PW-1:0] tail;
	logic          full;

	logic [7:0]         rd_q, rd_d;
	logic signed [15:0] smp_q, smp_d;
	logic               taken_q, taken_d;
	logic               irq_q, irq_d;

	logic                 div_start;
	logic [DIVISOR_W-1:0] div_operand;
	logic                 div_done;
	logic [RATE_W-1:0]    div_quot;

	adcp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_operand),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign tail_sum    = {{(CW + 1 - PW){1'b0}}, head_q} + {1'b0, count_q};
	assign tail        = (tail_sum >= (CW + 1)'(FIFO_DEPTH)) ?
		PW'(tail_sum - (CW + 1)'(FIFO_DEPTH)) : PW'(tail_sum);
	assign full        = count_q == COUNT_FULL;
	assign div_operand = DIVISOR_BASE - {1'b0, item_q.write_data};

	always_comb begin
		state_d   = state_q;
		pend_d    = pend_q;
		second_d  = second_q;
		active_d  = active_q;
		remain_d  = remain_q;
		spk_d     = spk_q;
		rate_d    = rate_q;
		head_d    = head_q;
		count_d   = count_q;
		rd_d      = rd_q;
		smp_d     = smp_q;
		taken_d   = taken_q;
		irq_d     = irq_q;
		wr_en     = 1'b0;
		wr_addr   = tail;
		wr_data   = item_q.write_data;
		div_start = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				rd_d    = 8'h00;
				smp_d   = '0;
				taken_d = 1'b0;
				irq_d   = 1'b0;
				state_d = ST_RESP;
				unique case (item_q.req_type)
					REQ_WRITE: begin
						if (item_q.port_offset == PORT_RESET) begin
							spk_d    = 1'b0;
							pend_d   = CMD_NONE;
							second_d = 1'b0;
							head_d   = '0;
							count_d  = CW'(1);
							wr_en    = 1'b1;
							wr_addr  = '0;
							wr_data  = RESET_REPLY;
						end else if (item_q.port_offset == PORT_COMMAND) begin
							if (pend_q != CMD_NONE) begin
								// Data byte of a latched command.
								pend_d = CMD_NONE;
								unique case (pend_q)
									CMD_PAUSE: begin
										if (!second_q) begin
											second_d = 1'b1;
											pend_d   = pend_q;
										end else begin
											second_d = 1'b0;
										end
									end
									CMD_DMA_LENGTH: begin
										if (!second_q) begin
											remain_d = {8'h00, item_q.write_data};
											second_d = 1'b1;
											pend_d   = pend_q;
										end else begin
											remain_d = {item_q.write_data, remain_q[7:0]};
											second_d = 1'b0;
											active_d = 1'b1;
										end
									end
									CMD_TIME_CONST: begin
										div_start = 1'b1;
										state_d   = ST_DIV;
									end
									CMD_INVERT: begin
										if (!full) begin
											wr_en   = 1'b1;
											wr_data = ~item_q.write_data;
											count_d = count_q + 1'b1;
										end
									end
									default: begin
									end
								endcase
							end else begin
								unique case (item_q.write_data)
									CMD_DMA_RESUME: active_d = 1'b1;
									CMD_DMA_HALT:   active_d = 1'b0;
									CMD_SPK_ON:     spk_d    = 1'b1;
									CMD_SPK_OFF:    spk_d    = 1'b0;
									CMD_VERSION: begin
										if (!full) begin
											wr_en   = 1'b1;
											wr_data = VERSION_MAJOR;
											count_d = count_q + 1'b1;
										end
										state_d = ST_PUSH2;
									end
									CMD_IRQ:        irq_d    = 1'b1;
									default:        pend_d   = item_q.write_data;
								endcase
							end
						end
					end
					REQ_READ: begin
						unique case (item_q.port_offset)
							PORT_DATA: begin
								if (count_q != '0) begin
									state_d = ST_POP;
								end
							end
							PORT_STATUS:  rd_d = (count_q != '0) ? STATUS_SET : STATUS_CLEAR;
							PORT_COMMAND: rd_d = (pend_q != CMD_NONE) ? STATUS_SET : STATUS_CLEAR;
							default:      rd_d = UNMAPPED_READ;
						endcase
					end
					REQ_TICK: begin
						if (active_q) begin
							if (remain_q != 16'h0000) begin
								remain_d = remain_q - 1'b1;
								taken_d  = 1'b1;
								if (spk_q) begin
									smp_d = {item_q.dma_byte ^ SAMPLE_BIAS, 8'h00};
								end
							end else begin
								active_d = 1'b0;
								irq_d    = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_PUSH2: begin
				if (!full) begin
					wr_en   = 1'b1;
					wr_data = VERSION_MINOR;
					count_d = count_q + 1'b1;
				end
				state_d = ST_RESP;
			end
			ST_POP: begin
				// The read of the head entry was issued at the edge into this state.
				rd_d    = rdata_q;
				head_d  = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
				count_d = count_q - 1'b1;
				state_d = ST_RESP;
			end
			ST_DIV: begin
				if (div_done) begin
					rate_d  = div_quot;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_q   <= CMD_NONE;
			second_q <= 1'b0;
			active_q <= 1'b0;
			remain_q <= '0;
			spk_q    <= 1'b0;
			rate_q   <= RATE_RESET;
			head_q   <= '0;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			pend_q   <= pend_d;
			second_q <= second_d;
			active_q <= active_d;
			remain_q <= remain_d;
			spk_q    <= spk_d;
			rate_q   <= rate_d;
			head_q   <= head_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_q <= cmd.data;
		end
		rd_q    <= rd_d;
		smp_q   <= smp_d;
		taken_q <= taken_d;
		irq_q   <= irq_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_mem[wr_addr] <= wr_data;
		end
		rdata_q <= fifo_mem[head_q];
	end

	assign cmd.ready = state_q == ST_IDLE;
	assign rsp.valid = state_q == ST_RESP;
	assign rsp.data  = '{
		read_data:      rd_q,
		sample_out:     smp_q,
		dma_taken:      taken_q,
		irq_pulse:      irq_q,
		sample_rate_hz: rate_q
	};

endmodule

>>> src/adcp_divider.sv
module adcp_divider import adcp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [RATE_W-1:0]    quotient
);

	localparam int STEP_W = $clog2(RATE_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [RATE_W-1:0]    num_q;

	logic [DIVISOR_W:0]   rem_shift;
	logic                 fits;
	logic [DIVISOR_W:0]   rem_sub;

	// Restoring division: the numerator shifts out the top while quotient bits
	// shift in at the bottom, one bit a cycle.
	assign rem_shift = {rem_q, num_q[RATE_W-1]};
	assign fits      = rem_shift >= {1'b0, div_q};
	assign rem_sub   = rem_shift - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			num_q <= RATE_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
			num_q <= {num_q[RATE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule
